@@ hdl/tplw_pkg.sv @@
// tplw_pkg: shared types and codes for the two-level page table walker
// depends on nothing; used by the store, the top level, both checkers and the testbench
`default_nettype none

package tplw_pkg;

    // operation codes
    localparam logic [1:0] FN_MAP   = 2'd0;
    localparam logic [1:0] FN_XLATE = 2'd1;
    localparam logic [1:0] FN_FLAGS = 2'd2;
    localparam logic [1:0] FN_NONE  = 2'd3;

    // fixed address split
    localparam int IDX_W    = 10;
    localparam int OFS_W    = 12;
    localparam int FRAME_W  = 20;
    localparam int LEAF_W   = 32;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  space_id;
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
        logic [11:0] entry_flags;
    } t_cmd;

    typedef struct packed {
        logic [31:0] phys_result;
        logic [11:0] flags_result;
        logic        present;
        logic        pool_empty;
    } t_res;

    // memory strobes from the walker to the store
    typedef struct packed {
        logic dir_re;
        logic dir_we;
        logic leaf_re;
        logic leaf_we;
    } t_mem_ctl;

endpackage

`default_nettype wire

@@ hdl/tplw_store.sv @@
// tplw_store: directory and leaf memories with the clearing sweep after reset
// depends on tplw_pkg
`default_nettype none

module tplw_store #(
    parameter  int NUM_SPACES = 4,
    parameter  int NUM_TABLES = 16,
    localparam int SW         = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1,
    localparam int TW         = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1,
    localparam int DAW        = SW + tplw_pkg::IDX_W,
    localparam int LAW        = TW + tplw_pkg::IDX_W,
    localparam int DWW        = TW + 1
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire tplw_pkg::t_mem_ctl     i_ctl,
    input  wire [DAW-1:0]               i_dir_addr,
    input  wire [DWW-1:0]               i_dir_wdata,
    input  wire [LAW-1:0]               i_leaf_addr,
    input  wire [tplw_pkg::LEAF_W-1:0]  i_leaf_wdata,
    output logic [DWW-1:0]              o_dir_rdata,
    output logic [tplw_pkg::LEAF_W-1:0] o_leaf_rdata,
    output logic                        o_clr_busy
);

    localparam int DIR_DEPTH  = NUM_SPACES * (1 << tplw_pkg::IDX_W);
    localparam int LEAF_DEPTH = NUM_TABLES * (1 << tplw_pkg::IDX_W);
    localparam int CAW        = (DAW > LAW) ? DAW : LAW;
    localparam int CLR_DEPTH  = (DIR_DEPTH > LEAF_DEPTH) ? DIR_DEPTH : LEAF_DEPTH;
    localparam logic [CAW:0] DIR_END  = (CAW+1)'(DIR_DEPTH);
    localparam logic [CAW:0] LEAF_END = (CAW+1)'(LEAF_DEPTH);
    localparam logic [CAW:0] CLR_LAST = (CAW+1)'(CLR_DEPTH - 1);

    logic [DWW-1:0]              dir_mem  [DIR_DEPTH];
    logic [tplw_pkg::LEAF_W-1:0] leaf_mem [LEAF_DEPTH];

    logic [CAW-1:0] r_clr_idx;
    logic           r_clr_busy;
    logic           clr_dir;
    logic           clr_leaf;

    // sweep range for each memory
    assign clr_dir  = r_clr_busy && ({1'b0, r_clr_idx} < DIR_END);
    assign clr_leaf = r_clr_busy && ({1'b0, r_clr_idx} < LEAF_END);

    // clearing counter, one entry of each memory per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            if ({1'b0, r_clr_idx} == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // directory memory
    always_ff @(posedge i_clk) begin
        if (clr_dir) begin
            dir_mem[r_clr_idx[DAW-1:0]] <= '0;
        end else if (i_ctl.dir_we) begin
            dir_mem[i_dir_addr] <= i_dir_wdata;
        end
        if (i_ctl.dir_re) begin
            o_dir_rdata <= dir_mem[i_dir_addr];
        end
    end

    // leaf memory
    always_ff @(posedge i_clk) begin
        if (clr_leaf) begin
            leaf_mem[r_clr_idx[LAW-1:0]] <= '0;
        end else if (i_ctl.leaf_we) begin
            leaf_mem[i_leaf_addr] <= i_leaf_wdata;
        end
        if (i_ctl.leaf_re) begin
            o_leaf_rdata <= leaf_mem[i_leaf_addr];
        end
    end

    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

@@ hdl/two_level_page_table_walker_top.sv @@
// two_level_page_table_walker_top: command sequencer of the page table walker
// depends on tplw_pkg and tplw_store
//
//  channel   | signals                 | direction | accepted when
//  ----------+-------------------------+-----------+-------------------------
//  command   | start, i_cmd, busy      | in        | start high, busy low
//  result    | o_done, o_res           | out       | o_done high (one cycle)
//
// sequence: a lookup that finds a directory entry runs a directory read, then a
// leaf read, then the result; a map or a lookup that misses the directory ends
// with the directory read; an unknown func or space answers straight from idle.
// The two dependent single-port memory reads set this order.
// reset: a sweep over max(NUM_SPACES, NUM_TABLES) * 1024 entries clears both
// memories; busy stays high meanwhile.
// stalls: the receiver cannot stall; a result beat may overlap the next start.
`default_nettype none

module two_level_page_table_walker_top #(
    parameter int NUM_SPACES = 4,
    parameter int NUM_TABLES = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  wire tplw_pkg::t_cmd i_cmd,
    output logic             o_done,
    output tplw_pkg::t_res   o_res
);

    localparam int SW  = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
    localparam int TW  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int UW  = $clog2(NUM_TABLES + 1);
    localparam int DAW = SW + tplw_pkg::IDX_W;
    localparam int LAW = TW + tplw_pkg::IDX_W;
    localparam int DWW = TW + 1;
    localparam logic [UW-1:0] TBL_LIMIT = UW'(NUM_TABLES);
    localparam logic [6:0]    SPC_LIMIT = 7'(NUM_SPACES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIR  = 2'd1;
    localparam logic [1:0] ST_LEAF = 2'd2;

    logic [1:0]           r_state, n_state;
    tplw_pkg::t_cmd       r_cmd;
    logic [UW-1:0]        r_used, n_used;
    logic                 r_done, n_done;
    tplw_pkg::t_res       r_res, n_res;

    tplw_pkg::t_mem_ctl   mem_ctl;
    logic [DAW-1:0]       dir_addr;
    logic [DWW-1:0]       dir_wdata;
    logic [DWW-1:0]       dir_rdata;
    logic [LAW-1:0]       leaf_addr;
    logic [tplw_pkg::LEAF_W-1:0] leaf_wdata;
    logic [tplw_pkg::LEAF_W-1:0] leaf_rdata;
    logic                 clr_busy;
    logic                 accept;
    logic                 cmd_ok;
    logic [TW-1:0]        tbl_sel;
    logic                 dir_valid;

    assign busy   = (r_state != ST_IDLE) || clr_busy;
    assign accept = start && !busy;

    // a command walks only for a known func and an existing space
    assign cmd_ok = (i_cmd.func != tplw_pkg::FN_NONE) &&
                    ({5'b0, i_cmd.space_id} < SPC_LIMIT);

    assign dir_valid = dir_rdata[DWW-1];

    // directory address from the port at accept, from the held command after
    assign dir_addr = (r_state == ST_IDLE)
                    ? {SW'(i_cmd.space_id), i_cmd.virt_addr[31:22]}
                    : {SW'(r_cmd.space_id), r_cmd.virt_addr[31:22]};

    // a fresh table comes from the pool count, otherwise from the directory
    assign tbl_sel    = dir_valid ? dir_rdata[TW-1:0] : r_used[TW-1:0];
    assign leaf_addr  = {tbl_sel, r_cmd.virt_addr[21:12]};
    assign dir_wdata  = {1'b1, r_used[TW-1:0]};
    assign leaf_wdata = {r_cmd.phys_addr[31:12], r_cmd.entry_flags};

    // sequencer
    always_comb begin
        n_state = r_state;
        n_used  = r_used;
        n_done  = 1'b0;
        n_res   = r_res;
        mem_ctl = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (cmd_ok) begin
                        mem_ctl.dir_re = 1'b1;
                        n_state        = ST_DIR;
                    end else begin
                        n_done = 1'b1;
                        n_res  = '0;
                    end
                end
            end
            ST_DIR: begin
                n_res   = '0;
                n_state = ST_IDLE;
                if (r_cmd.func == tplw_pkg::FN_MAP) begin
                    n_done = 1'b1;
                    if (dir_valid) begin
                        mem_ctl.leaf_we = 1'b1;
                    end else if (r_used >= TBL_LIMIT) begin
                        n_res.pool_empty = 1'b1;
                    end else begin
                        mem_ctl.dir_we  = 1'b1;
                        mem_ctl.leaf_we = 1'b1;
                        n_used          = r_used + 1'b1;
                    end
                end else if (dir_valid) begin
                    mem_ctl.leaf_re = 1'b1;
                    n_state         = ST_LEAF;
                end else begin
                    n_done = 1'b1;
                end
            end
            ST_LEAF: begin
                n_done  = 1'b1;
                n_res   = '0;
                n_state = ST_IDLE;
                if (leaf_rdata[0]) begin
                    n_res.phys_result  = {leaf_rdata[31:12], r_cmd.virt_addr[11:0]};
                    n_res.flags_result = leaf_rdata[11:0];
                    n_res.present      = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_res <= n_res;
    end

    tplw_store #(
        .NUM_SPACES (NUM_SPACES),
        .NUM_TABLES (NUM_TABLES)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mem_ctl),
        .i_dir_addr   (dir_addr),
        .i_dir_wdata  (dir_wdata),
        .i_leaf_addr  (leaf_addr),
        .i_leaf_wdata (leaf_wdata),
        .o_dir_rdata  (dir_rdata),
        .o_leaf_rdata (leaf_rdata),
        .o_clr_busy   (clr_busy)
    );

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

@@ hdl/tplw_checker.sv @@
// tplw_port_checker: port-level assertions for the page table walker
// depends on tplw_pkg; bound to two_level_page_table_walker_top
`default_nettype none

module tplw_port_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_start,
    input wire                 i_busy,
    input wire tplw_pkg::t_cmd i_cmd,
    input wire                 i_done,
    input wire tplw_pkg::t_res i_res
);

    // an unknown func answers with an all-zero beat in the next cycle
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy && i_cmd.func == tplw_pkg::FN_NONE)
        |=> (i_done && i_res == '0))
        else $error("unknown func did not give a zero beat");

    // a pool exhaustion beat carries no translation
    a_pool_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && i_res.pool_empty)
        |-> (!i_res.present && i_res.phys_result == '0 && i_res.flags_result == '0))
        else $error("pool_empty beat carries data");

    // a miss returns zero frame and flags
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && !i_res.present)
        |-> (i_res.phys_result == '0 && i_res.flags_result == '0))
        else $error("non-present beat carries data");

    // a hit has the present flag bit set and no pool flag
    a_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && i_res.present)
        |-> (i_res.flags_result[0] && !i_res.pool_empty))
        else $error("present beat without present flag");

endmodule

bind two_level_page_table_walker_top tplw_port_checker u_tplw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_cmd   (i_cmd),
    .i_done  (o_done),
    .i_res   (o_res)
);

`default_nettype wire

@@ verif/tplw_checker.sv @@
`timescale 1ns / 1ps
// tplw_checker: watches the command and result beats of the page table walker,
// keeps its own copy of the directories, leaf tables and pool, and compares
// depends on tplw_pkg
module tplw_checker #(
    parameter int NUM_SPACES = 4,
    parameter int NUM_TABLES = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire            i_busy,
    input  tplw_pkg::t_cmd i_cmd,
    input  wire            i_done,
    input  tplw_pkg::t_res i_res,
    output int             o_mismatches,
    output int             o_outstanding
);

    localparam int IDX_W = tplw_pkg::IDX_W;
    localparam int OFS_W = tplw_pkg::OFS_W;
    localparam int SLOTS = 1 << IDX_W;

    // shadow page tables
    bit          dir_live   [NUM_SPACES * SLOTS];
    int          dir_table  [NUM_SPACES * SLOTS];
    logic [31:0] leaf_store [NUM_TABLES * SLOTS];
    int          tables_taken;

    // results still owed by the walker, oldest first
    tplw_pkg::t_res pending_walks [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        o_mismatches++;
    endtask

    // walk the shadow tables for one command, updating them on a map
    function automatic tplw_pkg::t_res predict_walk(input tplw_pkg::t_cmd c);
        tplw_pkg::t_res r;
        int             slot;
        logic [31:0]    leaf;
        r = '0;
        if (c.func == tplw_pkg::FN_NONE || c.space_id >= NUM_SPACES)
            return r;
        slot = c.space_id * SLOTS + c.virt_addr[OFS_W + IDX_W +: IDX_W];
        if (c.func == tplw_pkg::FN_MAP) begin
            // a missing directory entry takes the next table from the pool
            if (!dir_live[slot]) begin
                if (tables_taken >= NUM_TABLES) begin
                    r.pool_empty = 1'b1;
                    return r;
                end
                dir_live[slot]  = 1'b1;
                dir_table[slot] = tables_taken;
                tables_taken++;
            end
            leaf_store[dir_table[slot] * SLOTS + c.virt_addr[OFS_W +: IDX_W]] =
                {c.phys_addr[31:OFS_W], c.entry_flags};
            return r;
        end
        if (!dir_live[slot])
            return r;
        leaf = leaf_store[dir_table[slot] * SLOTS + c.virt_addr[OFS_W +: IDX_W]];
        // a leaf without its present bit reads as all zeros
        if (!leaf[0])
            return r;
        r.phys_result  = {leaf[31:OFS_W], c.virt_addr[OFS_W-1:0]};
        r.flags_result = leaf[OFS_W-1:0];
        r.present      = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        tplw_pkg::t_res want;
        if (!i_rst_n) begin
            foreach (dir_live[k])
                dir_live[k] = 1'b0;
            foreach (leaf_store[k])
                leaf_store[k] = '0;
            tables_taken = 0;
            pending_walks.delete();
        end else begin
            // command beat
            if (i_start === 1'b1 && i_busy === 1'b0)
                pending_walks.push_back(predict_walk(i_cmd));
            // result beat
            if (i_done === 1'b1) begin
                if (pending_walks.size() == 0) begin
                    report_mismatch("result beat with no walk pending",
                                    i_res.phys_result, '0);
                end else begin
                    want = pending_walks.pop_front();
                    if (i_res.phys_result !== want.phys_result)
                        report_mismatch("phys_result", i_res.phys_result,
                                        want.phys_result);
                    if (i_res.flags_result !== want.flags_result)
                        report_mismatch("flags_result", 32'(i_res.flags_result),
                                        32'(want.flags_result));
                    if (i_res.present !== want.present)
                        report_mismatch("present", 32'(i_res.present),
                                        32'(want.present));
                    if (i_res.pool_empty !== want.pool_empty)
                        report_mismatch("pool_empty", 32'(i_res.pool_empty),
                                        32'(want.pool_empty));
                end
            end
        end
        o_outstanding = pending_walks.size();
    end

endmodule

@@ verif/two_level_page_table_walker_top_tb.sv @@
`timescale 1ns / 1ps
// two_level_page_table_walker_top_tb: drives command beats into the walker and
// gives the verdict; tplw_checker predicts and compares the result beats
// depends on tplw_pkg, two_level_page_table_walker_top and tplw_checker
module two_level_page_table_walker_top_tb;

    localparam int SPACES      = 4;
    localparam int TABLES      = 16;
    localparam int RANDOM_CMDS = 600;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    logic           o_done;
    tplw_pkg::t_cmd cmd;
    tplw_pkg::t_res res;
    int             mismatches;
    int             outstanding;

    // recent map commands, used to aim lookups and remaps at live tables
    tplw_pkg::t_cmd recent_maps [$];
    bit             steady;

    two_level_page_table_walker_top #(
        .NUM_SPACES(SPACES),
        .NUM_TABLES(TABLES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_cmd  (cmd),
        .o_done (o_done),
        .o_res  (res)
    );

    tplw_checker #(
        .NUM_SPACES(SPACES),
        .NUM_TABLES(TABLES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_done       (o_done),
        .i_res        (res),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // one command beat: optional gap, then hold start until busy is low
    task automatic drive_beat(input tplw_pkg::t_cmd c);
        int gap;
        if ($urandom_range(99) < 4)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        cmd   <= c;
        if (c.func == tplw_pkg::FN_MAP) begin
            recent_maps.push_back(c);
            if (recent_maps.size() > 48)
                void'(recent_maps.pop_front());
        end
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [1:0] fn, input logic [1:0] sp,
                         input logic [31:0] va, input logic [31:0] pa,
                         input logic [11:0] fl);
        tplw_pkg::t_cmd c;
        c.func        = fn;
        c.space_id    = sp;
        c.virt_addr   = va;
        c.phys_addr   = pa;
        c.entry_flags = fl;
        drive_beat(c);
    endtask

    // mostly commands near recent maps, the rest anywhere
    function automatic tplw_pkg::t_cmd random_cmd();
        tplw_pkg::t_cmd c;
        tplw_pkg::t_cmd near;
        int             pick;
        pick = $urandom_range(99);
        if (pick < 35)
            c.func = tplw_pkg::FN_MAP;
        else if (pick < 65)
            c.func = tplw_pkg::FN_XLATE;
        else if (pick < 92)
            c.func = tplw_pkg::FN_FLAGS;
        else
            c.func = tplw_pkg::FN_NONE;
        c.space_id    = 2'($urandom_range(3));
        c.virt_addr   = $urandom;
        c.phys_addr   = $urandom;
        c.entry_flags = 12'($urandom_range(4095));
        if (c.func == tplw_pkg::FN_MAP && $urandom_range(99) < 75)
            c.entry_flags[0] = 1'b1;
        if (recent_maps.size() != 0 && $urandom_range(99) < 80) begin
            near = recent_maps[$urandom_range(recent_maps.size() - 1)];
            c.space_id = near.space_id;
            c.virt_addr[31:22] = near.virt_addr[31:22];
            if ($urandom_range(99) < 60)
                c.virt_addr[21:12] = near.virt_addr[21:12];
        end
        return c;
    endfunction

    // run limit
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        tplw_pkg::t_cmd c;
        int             counted;
        int             waited;
        i_rst_n = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        steady  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lookup before anything is mapped
        issue(tplw_pkg::FN_XLATE, 2'd0, 32'h0000_0000, 32'h0, 12'h0);
        // all-ones frame and flags
        issue(tplw_pkg::FN_MAP, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        issue(tplw_pkg::FN_XLATE, 2'd0, 32'h0000_0ABC, 32'h0, 12'h0);
        issue(tplw_pkg::FN_FLAGS, 2'd0, 32'h0000_0FFF, 32'hFFFF_FFFF, 12'hFFF);
        // zero frame at the top of the space, low phys bits ignored
        issue(tplw_pkg::FN_MAP, 2'd3, 32'hFFFF_FFFF, 32'h0000_0FFF, 12'h001);
        issue(tplw_pkg::FN_XLATE, 2'd3, 32'hFFFF_F123, 32'h0, 12'h0);
        // leaf stored without its present bit
        issue(tplw_pkg::FN_MAP, 2'd2, 32'h1234_5678, 32'hABCD_E000, 12'hFFE);
        issue(tplw_pkg::FN_FLAGS, 2'd2, 32'h1234_5000, 32'h0, 12'h0);
        // same table, leaf never written
        issue(tplw_pkg::FN_XLATE, 2'd2, 32'h1234_6000, 32'h0, 12'h0);
        // unknown func changes nothing
        issue(tplw_pkg::FN_NONE, 2'd1, 32'h0000_0000, 32'h1000_0000, 12'h001);
        // other space shares nothing with space 0
        issue(tplw_pkg::FN_XLATE, 2'd1, 32'h0000_0000, 32'h0, 12'h0);
        // take the rest of the pool
        for (int k = 0; k < TABLES - 3; k++)
            issue(tplw_pkg::FN_MAP, 2'd1, ((k + 1) << 22) | (k << 12), $urandom,
                  12'h001);
        // empty pool: nothing written
        issue(tplw_pkg::FN_MAP, 2'd1, 32'hFFC0_0000, 32'h5555_5000, 12'h001);
        issue(tplw_pkg::FN_XLATE, 2'd1, 32'hFFC0_0000, 32'h0, 12'h0);
        // an existing directory entry still maps
        issue(tplw_pkg::FN_MAP, 2'd0, 32'h0000_1000, 32'h8000_0000, 12'h003);

        // random part
        counted = 0;
        while (counted < RANDOM_CMDS) begin
            c = random_cmd();
            counted++;
            drive_beat(c);
        end
        start <= 1'b0;

        // drain
        for (waited = 0; waited < 200 && outstanding != 0; waited++)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/tplw_pkg.sv
hdl/tplw_store.sv
hdl/two_level_page_table_walker_top.sv
hdl/tplw_checker.sv
verif/tplw_checker.sv
verif/two_level_page_table_walker_top_tb.sv
